FILE: src/tedc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, item types and wave types for the token edit distance core.
package tedc_pkg;

   localparam int MAX_LEN    = 64;
   localparam int SYM_W      = 21;
   localparam int DISTANCE_W = 7;
   localparam int DIST_W     = $clog2(MAX_LEN + 1);
   localparam int CNT_W      = $clog2(MAX_LEN + 2);

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_CAND   = 2'd2;
   localparam logic [1:0] KIND_CLOSE  = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [SYM_W-1:0] symbol;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [DISTANCE_W-1:0] distance;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [DIST_W-1:0] index;
      logic [SYM_W-1:0]  sym;
   } ref_wr_type;

   typedef struct packed {
      logic              valid;
      logic              upd;
      logic              first;
      logic              cap;
      logic              ovf;
      logic [SYM_W-1:0]  sym;
      logic [DIST_W-1:0] left_new;
      logic [DIST_W-1:0] left_old;
      logic [DIST_W-1:0] target;
      logic [DIST_W-1:0] res;
   } wave_type;

endpackage

FILE: src/tedc_cell.sv
`timescale 1ns / 1ps
// One cell of the distance chain: holds a reference symbol and one distance entry.
module tedc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [tedc_pkg::DIST_W-1:0] cell_index,
   input  tedc_pkg::ref_wr_type       ref_wr,
   input  tedc_pkg::wave_type         wave_in,
   output tedc_pkg::wave_type         wave_out
);
   import tedc_pkg::*;

   logic [SYM_W-1:0]  sym_ff;
   logic [DIST_W-1:0] d_ff;
   logic [DIST_W-1:0] d_in;
   wave_type          wave_ff;
   wave_type          wave_in_next;

   logic [DIST_W-1:0] own_old;
   logic [DIST_W-1:0] new_d;
   logic [DIST_W-1:0] cur;
   logic [DIST_W:0]   up_cost;
   logic [DIST_W:0]   left_cost;
   logic [DIST_W:0]   diag_cost;
   logic [DIST_W:0]   min_ab;
   logic [DIST_W:0]   min_abc;

   always_comb begin
      own_old   = wave_in.first ? cell_index : d_ff;
      up_cost   = (DIST_W+1)'(own_old) + 1'b1;
      left_cost = (DIST_W+1)'(wave_in.left_new) + 1'b1;
      diag_cost = (DIST_W+1)'(wave_in.left_old) + ((sym_ff != wave_in.sym) ? 1'b1 : 1'b0);
      min_ab    = (up_cost < left_cost) ? up_cost : left_cost;
      min_abc   = (min_ab < diag_cost) ? min_ab : diag_cost;
      new_d     = DIST_W'(min_abc);
      cur       = wave_in.upd ? new_d : own_old;

      d_in = d_ff;
      if (wave_in.valid && wave_in.upd) begin
         d_in = new_d;
      end

      wave_in_next          = wave_in;
      wave_in_next.left_new = cur;
      wave_in_next.left_old = own_old;
      if (wave_in.cap && (wave_in.target == cell_index)) begin
         wave_in_next.res = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_wr.en && (ref_wr.index == cell_index)) begin
         sym_ff <= ref_wr.sym;
      end
      d_ff <= d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff.valid <= 1'b0;
      end else begin
         wave_ff <= wave_in_next;
      end
   end

   assign wave_out = wave_ff;

endmodule

FILE: src/token_edit_distance_core.sv
`timescale 1ns / 1ps
// Top level of the token edit distance core: item control and the chain of cells.
// The block keeps the reference in a chain of MAX_LEN cells, one per reference position, and
// each candidate symbol travels down the chain as a wave, one cell per cycle, so candidate
// symbols are taken one per cycle, but a closing one may wait. The item that closes a
// candidate (a candidate symbol marked last, or a close item) gives its result once its wave
// has left the chain. A closing item is taken only when no earlier result is still travelling
// or waiting in the output register; clear, append and other candidate items are taken at
// once. Overlong references and candidates set the overflow bit of the result.
module token_edit_distance_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tedc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tedc_pkg::rsp_type rsp_data
);
   import tedc_pkg::*;

   logic [DIST_W-1:0] ref_len_ff,  ref_len_in;
   logic [CNT_W-1:0]  cand_ff,     cand_in;
   logic              ovf_ff,      ovf_in;
   logic              busy_ff,     busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   wave_type          wave_ff,     wave_in;
   ref_wr_type        ref_wr;

   wave_type          chain [MAX_LEN+1];

   logic              accept;
   logic              emitting;
   logic [CNT_W-1:0]  cand_next;
   logic [DIST_W-1:0] d0_next;
   wave_type          tail;

   assign emitting  = ((req_data.kind == KIND_CAND) && req_data.last) ||
                      (req_data.kind == KIND_CLOSE);
   assign req_ready = !emitting || (!busy_ff && !rsp_valid_ff);
   assign accept    = req_valid && req_ready;
   assign tail      = chain[MAX_LEN];

   always_comb begin
      ref_len_in   = ref_len_ff;
      cand_in      = cand_ff;
      ovf_in       = ovf_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ref_wr       = '0;
      wave_in      = '0;
      cand_next    = cand_ff;
      d0_next      = (cand_ff > CNT_W'(MAX_LEN)) ? DIST_W'(MAX_LEN) : DIST_W'(cand_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tail.valid && tail.cap) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.distance = DISTANCE_W'(tail.res);
         rsp_data_in.overflow = tail.ovf;
         busy_in              = 1'b0;
      end

      if (accept) begin
         case (req_data.kind)
            KIND_CLEAR: begin
               ref_len_in = '0;
               ovf_in     = 1'b0;
               cand_in    = '0;
            end
            KIND_APPEND: begin
               cand_in = '0;
               if (ref_len_ff < DIST_W'(MAX_LEN)) begin
                  ref_wr.en    = 1'b1;
                  ref_wr.index = ref_len_ff + 1'b1;
                  ref_wr.sym   = req_data.symbol;
                  ref_len_in   = ref_len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            KIND_CAND: begin
               wave_in.sym    = req_data.symbol;
               wave_in.target = ref_len_ff;
               wave_in.cap    = req_data.last;
               if (cand_ff < CNT_W'(MAX_LEN)) begin
                  cand_next        = cand_ff + 1'b1;
                  wave_in.upd      = 1'b1;
                  wave_in.first    = (cand_ff == '0);
                  wave_in.left_old = DIST_W'(cand_ff);
                  wave_in.left_new = DIST_W'(cand_next);
                  d0_next          = DIST_W'(cand_next);
               end else begin
                  cand_next = CNT_W'(MAX_LEN + 1);
                  d0_next   = DIST_W'(MAX_LEN);
               end
               wave_in.valid = wave_in.upd || req_data.last;
               wave_in.res   = d0_next;
               wave_in.ovf   = ovf_ff || (cand_next > CNT_W'(MAX_LEN));
               cand_in       = req_data.last ? '0 : cand_next;
               if (req_data.last) begin
                  busy_in = 1'b1;
               end
            end
            KIND_CLOSE: begin
               wave_in.valid  = 1'b1;
               wave_in.cap    = 1'b1;
               wave_in.first  = (cand_ff == '0);
               wave_in.target = ref_len_ff;
               wave_in.res    = d0_next;
               wave_in.ovf    = ovf_ff || (cand_ff > CNT_W'(MAX_LEN));
               cand_in        = '0;
               busy_in        = 1'b1;
            end
            default: begin
               cand_in = cand_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff    <= '0;
         cand_ff       <= '0;
         ovf_ff        <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wave_ff.valid <= 1'b0;
      end else begin
         ref_len_ff   <= ref_len_in;
         cand_ff      <= cand_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         wave_ff      <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign chain[0] = wave_ff;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      tedc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (DIST_W'(k + 1)),
         .ref_wr     (ref_wr),
         .wave_in    (chain[k]),
         .wave_out   (chain[k+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/tedc_checker.sv
`timescale 1ns / 1ps
// Port checker for the token edit distance core and its bind to the top level.
module tedc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tedc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tedc_pkg::rsp_type rsp_data
);
   import tedc_pkg::*;

   logic emit_item;
   logic emit_accept;

   assign emit_item   = ((req_data.kind == KIND_CAND) && req_data.last) ||
                        (req_data.kind == KIND_CLOSE);
   assign emit_accept = req_valid && req_ready && emit_item;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result item shown straight after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      emit_accept |=> !(req_valid && emit_item && req_ready))
      else $error("second closing item taken while a result is in flight");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(emit_accept))
      else $error("result item appeared too soon after its closing item");

endmodule

bind token_edit_distance_core tedc_checker u_tedc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: test/token_edit_distance_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the token edit distance core, with a predictor and random traffic.
module token_edit_distance_core_tb;
   import tedc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEM_TARGET = 1950;
   localparam logic [SYM_W-1:0] SYM_TOP = 21'd1114111;

   typedef struct {
      req_type item;
      bit      drain;
   } pending_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pending_item_type pending_items[$];
   rsp_type          expected_distances[$];
   logic [SYM_W-1:0] ref_copy[$];
   int               queued_count = 0;
   int               error_count = 0;
   int               quiet_cycles = 0;

   // Predictor state: one column of the distance matrix, indexed by reference position.
   logic [SYM_W-1:0] ref_syms[MAX_LEN];
   int unsigned      ref_len;
   int unsigned      cand_len;
   int unsigned      dist_col[MAX_LEN+1];
   bit               ref_overflow;

   bit sending = 1'b0;
   bit send_idle_off = 1'b0;
   int send_gap = 0;
   bit recv_idle_off = 1'b0;
   int recv_stall = 0;

   token_edit_distance_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void restart_column();
      for (int i = 0; i <= MAX_LEN; i++) begin
         dist_col[i] = i;
      end
      cand_len = 0;
   endfunction

   function automatic void reset_distance_state();
      ref_len = 0;
      ref_overflow = 1'b0;
      restart_column();
   endfunction

   function automatic rsp_type close_candidate();
      rsp_type result;
      result.distance = DISTANCE_W'(dist_col[ref_len]);
      result.overflow = ref_overflow || (cand_len > MAX_LEN);
      restart_column();
      return result;
   endfunction

   function automatic bit apply_item(input req_type item, output rsp_type result);
      int unsigned diag;
      int unsigned up;
      int unsigned best;
      result = '0;
      case (item.kind)
         KIND_CLEAR: begin
            reset_distance_state();
            return 1'b0;
         end
         KIND_APPEND: begin
            restart_column();
            if (ref_len < MAX_LEN) begin
               ref_syms[ref_len] = item.symbol;
               ref_len++;
            end else begin
               ref_overflow = 1'b1;
            end
            return 1'b0;
         end
         KIND_CLOSE: begin
            result = close_candidate();
            return 1'b1;
         end
         default: begin
            if (cand_len < MAX_LEN) begin
               diag = dist_col[0];
               cand_len++;
               dist_col[0] = cand_len;
               for (int i = 1; i <= ref_len; i++) begin
                  up = dist_col[i];
                  best = up + 1;
                  if (dist_col[i-1] + 1 < best) best = dist_col[i-1] + 1;
                  if (diag + (ref_syms[i-1] != item.symbol) < best)
                     best = diag + (ref_syms[i-1] != item.symbol);
                  dist_col[i] = best;
                  diag = up;
               end
            end else begin
               cand_len = MAX_LEN + 1;
            end
            if (item.last) begin
               result = close_candidate();
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol();
      case ($urandom_range(0, 9))
         6, 7:    return SYM_W'($urandom_range(0, 1114111));
         8:       return '0;
         9:       return SYM_TOP;
         default: return SYM_W'($urandom_range(65, 68));
      endcase
   endfunction

   function automatic int draw_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return MAX_LEN;
      if (r < 6) return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
      if (r < 14) return 0;
      return $urandom_range(1, 10);
   endfunction

   task automatic queue_item(input logic [1:0] kind, input logic [SYM_W-1:0] symbol,
                             input logic last, input bit drain = 1'b0);
      pending_item_type p;
      p.item.kind = kind;
      p.item.symbol = symbol;
      p.item.last = last;
      p.drain = drain;
      pending_items = {pending_items, p};
      queued_count++;
   endtask

   task automatic queue_reference(input int n, input bit drain);
      logic [SYM_W-1:0] sym;
      queue_item(KIND_CLEAR, pick_symbol(), 1'($urandom_range(0, 1)), drain);
      ref_copy.delete();
      for (int i = 0; i < n; i++) begin
         sym = pick_symbol();
         queue_item(KIND_APPEND, sym, 1'($urandom_range(0, 1)));
         ref_copy = {ref_copy, sym};
      end
   endtask

   task automatic queue_candidate(input int m);
      bit               close_early;
      logic [SYM_W-1:0] sym;
      if (m == 0) begin
         queue_item(KIND_CLOSE, pick_symbol(), 1'($urandom_range(0, 1)));
      end else begin
         close_early = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < m; i++) begin
            if (i < ref_copy.size() && $urandom_range(0, 1)) sym = ref_copy[i];
            else sym = pick_symbol();
            queue_item(KIND_CAND, sym, (i == m - 1) && !close_early);
         end
         if (close_early) queue_item(KIND_CLOSE, pick_symbol(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 4)) begin
         queue_item(2'($urandom_range(0, 3)), pick_symbol(), 1'($urandom_range(0, 1)));
      end
   endtask

   always begin
      bit      taken;
      bit      has_result;
      rsp_type result;
      pending_item_type next;
      @(posedge clock);
      taken = !reset && req_valid && req_ready;
      @(negedge clock);
      if (taken) begin
         has_result = apply_item(req_data, result);
         if (has_result) expected_distances = {expected_distances, result};
         sending = 1'b0;
         send_gap = send_idle_off ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 63) == 0) send_idle_off = !send_idle_off;
      end
      if (!sending && !reset && pending_items.size() != 0) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (!(pending_items[0].drain && expected_distances.size() != 0)) begin
            next = pending_items.pop_front();
            req_data <= next.item;
            sending = 1'b1;
         end
      end
      req_valid <= sending;
   end

   always begin
      bit      seen_valid;
      rsp_type want;
      @(posedge clock);
      seen_valid = !reset && rsp_valid;
      if (seen_valid && rsp_ready) begin
         if (expected_distances.size() == 0) begin
            $error("unexpected result: distance %0d overflow %0b",
                   rsp_data.distance, rsp_data.overflow);
            error_count++;
         end else begin
            want = expected_distances.pop_front();
            if (want.distance !== rsp_data.distance) begin
               $error("distance: expected %0d, actual %0d", want.distance, rsp_data.distance);
               error_count++;
            end
            if (want.overflow !== rsp_data.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow, rsp_data.overflow);
               error_count++;
            end
         end
         seen_valid = 1'b0;
         recv_stall = recv_idle_off ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 31) == 0) recv_idle_off = !recv_idle_off;
      end
      @(negedge clock);
      if (recv_stall > 0) begin
         if (seen_valid) recv_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset_distance_state();

      queue_item(KIND_CLOSE, '0, 1'b0);
      queue_item(KIND_CAND, SYM_TOP, 1'b1);
      queue_item(KIND_APPEND, '0, 1'b1);
      queue_item(KIND_APPEND, SYM_TOP, 1'b0);
      queue_item(KIND_APPEND, 21'd65, 1'b0);
      queue_item(KIND_CAND, '0, 1'b0);
      queue_item(KIND_CAND, SYM_TOP, 1'b0);
      queue_item(KIND_CAND, 21'd65, 1'b1);
      queue_item(KIND_CAND, 21'd66, 1'b0);
      queue_item(KIND_APPEND, 21'd66, 1'b0);
      queue_item(KIND_CAND, '0, 1'b0);
      queue_item(KIND_CLOSE, SYM_TOP, 1'b1);
      queue_item(KIND_CLOSE, 21'd65, 1'b0);
      queue_item(KIND_CAND, 21'd65, 1'b0);
      queue_item(KIND_CLEAR, SYM_TOP, 1'b1);
      queue_item(KIND_CAND, 21'd7, 1'b1);
      queue_item(KIND_APPEND, 21'd5, 1'b0);
      queue_item(KIND_CAND, 21'd6, 1'b1);
      queue_item(KIND_CAND, 21'd5, 1'b0);
      queue_item(KIND_CAND, 21'd5, 1'b1);

      queue_reference(MAX_LEN + 6, 1'b1);
      queue_candidate(MAX_LEN + 2);
      queue_candidate(MAX_LEN);
      queue_reference(MAX_LEN, 1'b0);
      queue_candidate(MAX_LEN);
      queue_candidate(MAX_LEN + 1);

      while (queued_count < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 2) begin
            queue_noise();
         end else begin
            if (ref_copy.size() == 0 || $urandom_range(0, 1))
               queue_reference(draw_length(), $urandom_range(0, 24) == 0);
            repeat ($urandom_range(1, 3)) queue_candidate(draw_length());
         end
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (MAX_LEN + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: token_edit_distance_core.f
src/tedc_pkg.sv
src/tedc_cell.sv
src/token_edit_distance_core.sv
src/tedc_checker.sv
test/token_edit_distance_core_tb.sv
